@@ hw/rtl/sld_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the STA/LTA event detector.
// No dependencies; imported by every other file of the block.
package sld_pkg;

  // Field and register widths
  localparam int SHORT_LEN_W = 12;
  localparam int LONG_LEN_W  = 13;
  localparam int WRATIO_W    = 13;
  localparam int LEVEL_W     = 24;
  localparam int EVLEN_W     = 32;
  localparam int EVNUM_W     = 16;
  localparam int IDX_W       = 32;
  localparam int SUM_W       = 44;
  localparam int RATIO_W     = 24;
  localparam int FRAC_W      = 8;
  localparam int INT_W       = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Ratio datapath: 44 x 13 product, split into two 22-bit halves
  localparam int MUL_SPLIT = 22;
  localparam int PROD_W    = MUL_SPLIT + WRATIO_W;
  localparam int NUM_W     = SUM_W + WRATIO_W;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CYCLES = RATIO_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);
  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [SHORT_LEN_W-1:0] SHORT_LEN_RST = 12'd100;
  localparam logic [LONG_LEN_W-1:0]  LONG_LEN_RST  = 13'd1000;
  localparam logic [WRATIO_W-1:0]    WRATIO_RST    = 13'd10;
  localparam logic [LEVEL_W-1:0]     GATE_RST      = 24'd819;
  localparam logic [LEVEL_W-1:0]     RELEASE_RST   = 24'd307;
  localparam logic [EVLEN_W-1:0]     EVLEN_RST     = 32'd15000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_LEN     = 3'd0,
    REG_LONG_LEN      = 3'd1,
    REG_WINDOW_RATIO  = 3'd2,
    REG_GATE_LEVEL    = 3'd3,
    REG_RELEASE_LEVEL = 3'd4,
    REG_MAX_EVENT_LEN = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [SHORT_LEN_W-1:0] short_len;
    logic [LONG_LEN_W-1:0]  long_len;
    logic [WRATIO_W-1:0]    window_ratio;
    logic [LEVEL_W-1:0]     gate_level;
    logic [LEVEL_W-1:0]     release_level;
    logic [EVLEN_W-1:0]     max_event_len;
  } sld_cfg_t;

  // One classified sample handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] short_sum;
    logic [SUM_W-1:0] long_sum;
    logic [IDX_W-1:0] idx;
    logic             warm;
  } sld_entry_t;

  typedef struct packed {
    logic [RATIO_W-1:0] energy_ratio;
    logic               detecting;
    logic               event_closed;
    logic [EVNUM_W-1:0] event_number;
    logic [IDX_W-1:0]   event_start;
    logic [IDX_W-1:0]   event_end;
  } sld_result_t;

  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL_LO,
    B_MUL_HI,
    B_CHECK,
    B_DIV,
    B_FINISH
  } back_state_t;

endpackage

@@ hw/rtl/sta_lta_event_detector_core.sv @@
`timescale 1ns / 1ps
// Top level of the STA/LTA event detector: configuration registers and block wiring.
// Depends on sld_pkg, sld_front, sld_queue and sld_back.
//
// One result per accepted envelope sample. The front end takes a sample in two
// steps (history read, then sum update) and none while the queue is full, so the
// back end sets the rate: a divided sample passes through queue pop, two multiply
// halves, saturation check, radix-4 divider iterations and output; a sample in
// warm-up, with an empty long window or a saturated ratio skips the divider.
// A two-entry queue lets the front end run ahead of the divider, and the
// output register lets the next sample be worked on while a result waits.
// The history memory needs no clearing pass after reset: a fill count marks
// entries not yet written, which read as zero. Configuration is to be written
// only while the block is idle; the block itself does not enforce this.
module sta_lta_event_detector_core #(
  parameter int MAX_WINDOW  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sld_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic [SAMPLE_BITS-1:0]              envelope_sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [sld_pkg::RATIO_W-1:0]         energy_ratio,
  output logic                                detecting,
  output logic                                event_closed,
  output logic [sld_pkg::EVNUM_W-1:0]         event_number,
  output logic [sld_pkg::IDX_W-1:0]           event_start,
  output logic [sld_pkg::IDX_W-1:0]           event_end
);
  import sld_pkg::*;

  sld_cfg_t    cfg;
  sld_entry_t  push_data, pop_data;
  sld_result_t result;
  logic        push, pop, full, not_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_len     <= SHORT_LEN_RST;
      cfg.long_len      <= LONG_LEN_RST;
      cfg.window_ratio  <= WRATIO_RST;
      cfg.gate_level    <= GATE_RST;
      cfg.release_level <= RELEASE_RST;
      cfg.max_event_len <= EVLEN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SHORT_LEN:     cfg.short_len     <= cfg_data[SHORT_LEN_W-1:0];
        REG_LONG_LEN:      cfg.long_len      <= cfg_data[LONG_LEN_W-1:0];
        REG_WINDOW_RATIO:  cfg.window_ratio  <= cfg_data[WRATIO_W-1:0];
        REG_GATE_LEVEL:    cfg.gate_level    <= cfg_data[LEVEL_W-1:0];
        REG_RELEASE_LEVEL: cfg.release_level <= cfg_data[LEVEL_W-1:0];
        REG_MAX_EVENT_LEN: cfg.max_event_len <= cfg_data[EVLEN_W-1:0];
        default: ;
      endcase
    end
  end

  sld_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .sample_valid    (sample_valid),
    .sample_ready    (sample_ready),
    .envelope_sample (envelope_sample),
    .full            (full),
    .push            (push),
    .entry           (push_data)
  );

  sld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  sld_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (not_empty),
    .q_data       (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign energy_ratio = result.energy_ratio;
  assign detecting    = result.detecting;
  assign event_closed = result.event_closed;
  assign event_number = result.event_number;
  assign event_start  = result.event_start;
  assign event_end    = result.event_end;

endmodule

@@ hw/rtl/sld_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts samples, keeps the squared-sample history and the window sums.
// Depends on sld_pkg; feeds sld_queue.
module sld_front #(
  parameter int MAX_WINDOW  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sld_pkg::sld_cfg_t         cfg,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  logic [SAMPLE_BITS-1:0]    envelope_sample,
  input  logic                      full,
  output logic                      push,
  output sld_pkg::sld_entry_t       entry
);
  import sld_pkg::*;

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int PW    = LEN_W + 1;
  localparam int SQ_W  = 2 * SAMPLE_BITS;

  // Length of zero acts as one, oversize acts as the full history
  function automatic logic [LEN_W-1:0] clamp_len(input logic [31:0] v);
    if (v == 32'd0) return LEN_W'(1);
    else if (v > 32'(MAX_WINDOW)) return LEN_W'(MAX_WINDOW);
    else return LEN_W'(v);
  endfunction

  // Ring position len entries behind pos
  function automatic logic [AW-1:0] back_pos(input logic [AW-1:0] pos,
                                             input logic [LEN_W-1:0] len);
    logic [PW-1:0] p;
    logic [PW-1:0] l;
    p = PW'(pos);
    l = PW'(len);
    if (p >= l) return AW'(p - l);
    else return AW'(p + PW'(MAX_WINDOW) - l);
  endfunction

  front_state_t state, state_next;

  logic [SQ_W-1:0]  hist [MAX_WINDOW];
  logic [SQ_W-1:0]  rd_s, rd_l, sq_q;
  logic             s_hit, l_hit, warm_q;
  logic [AW-1:0]    ring_pos;
  logic [LEN_W-1:0] fill_cnt;
  logic [IDX_W-1:0] sample_index;
  logic [SUM_W-1:0] short_sum, long_sum, short_sum_next, long_sum_next;

  logic [LEN_W-1:0] s_len, l_len;
  logic [AW-1:0]    old_s_pos, old_l_pos;
  logic [SQ_W-1:0]  sq;
  logic             accept, mem_we;

  assign s_len     = clamp_len(32'(cfg.short_len));
  assign l_len     = clamp_len(32'(cfg.long_len));
  assign old_s_pos = back_pos(ring_pos, s_len);
  assign old_l_pos = back_pos(ring_pos, l_len);
  assign sq        = SQ_W'(envelope_sample) * SQ_W'(envelope_sample);
  assign accept    = sample_valid && sample_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:   if (accept) state_next = F_UPDATE;
      F_UPDATE: state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    sample_ready = 1'b0;
    push         = 1'b0;
    mem_we       = 1'b0;
    unique case (state)
      F_IDLE:   sample_ready = !full;
      F_UPDATE: begin
        push   = 1'b1;
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  // History memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) hist[ring_pos] <= sq_q;
    if (accept) begin
      rd_s <= hist[old_s_pos];
      rd_l <= hist[old_l_pos];
    end
  end

  // Capture the sample and classify it; entries never written read as zero
  always_ff @(posedge clk) begin
    if (accept) begin
      sq_q   <= sq;
      s_hit  <= s_len <= fill_cnt;
      l_hit  <= l_len <= fill_cnt;
      warm_q <= sample_index < IDX_W'(l_len);
    end
  end

  // Running sums, wrapping at the sum width
  always_comb begin
    short_sum_next = short_sum + SUM_W'(sq_q) - (s_hit ? SUM_W'(rd_s) : '0);
    long_sum_next  = long_sum + SUM_W'(sq_q) - (l_hit ? SUM_W'(rd_l) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_sum    <= '0;
      long_sum     <= '0;
      ring_pos     <= '0;
      fill_cnt     <= '0;
      sample_index <= '0;
    end else if (push) begin
      short_sum    <= short_sum_next;
      long_sum     <= long_sum_next;
      ring_pos     <= (ring_pos == AW'(MAX_WINDOW - 1)) ? '0 : ring_pos + AW'(1);
      if (fill_cnt != LEN_W'(MAX_WINDOW)) fill_cnt <= fill_cnt + LEN_W'(1);
      sample_index <= sample_index + IDX_W'(1);
    end
  end

  assign entry.short_sum = short_sum_next;
  assign entry.long_sum  = long_sum_next;
  assign entry.idx       = sample_index;
  assign entry.warm      = warm_q;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= LEN_W'(MAX_WINDOW))
    else $error("history fill count beyond window");

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

@@ hw/rtl/sld_queue.sv @@
`timescale 1ns / 1ps
// Short queue between front and back ends, holding classified samples.
// Depends on sld_pkg.
module sld_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sld_pkg::sld_entry_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output sld_pkg::sld_entry_t  pop_data
);
  import sld_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sld_entry_t      slots [QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = count == CW'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QW'(1);
      if (pop)  rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

@@ hw/rtl/sld_back.sv @@
`timescale 1ns / 1ps
// Back end: ratio multiply, radix-4 restoring divide, trigger hysteresis, output register.
// Depends on sld_pkg; fed by sld_queue.
module sld_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sld_pkg::sld_cfg_t    cfg,
  input  logic                 q_valid,
  input  sld_pkg::sld_entry_t  q_data,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_ready,
  output sld_pkg::sld_result_t result
);
  import sld_pkg::*;

  back_state_t state, state_next;

  logic [SUM_W-1:0]     s_q, l_q, rem;
  logic [IDX_W-1:0]     idx_q;
  logic                 warm_q;
  logic [NUM_W-1:0]     num;
  logic [RATIO_W-1:0]   dq, ratio_q;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                 active;
  logic [EVNUM_W-1:0]   trig_cnt;
  logic [IDX_W-1:0]     trig_idx;

  logic [MUL_SPLIT-1:0] mul_a;
  logic [PROD_W-1:0]    prod;
  logic                 zero_ratio, saturate;
  logic [SUM_W:0]       t1, t2;
  logic                 ge1, ge2;
  logic [SUM_W-1:0]     r1, r2;
  logic [RATIO_W-1:0]   dq_next;
  logic                 load;

  logic                 trig, act_mid, close;
  logic [EVNUM_W-1:0]   tc_mid;
  logic [IDX_W-1:0]     ti_mid;

  // Shared 22 x 13 multiplier for both halves of the short sum
  assign mul_a = (state == B_MUL_LO) ? s_q[MUL_SPLIT-1:0] : s_q[SUM_W-1:MUL_SPLIT];
  assign prod  = PROD_W'(mul_a) * PROD_W'(cfg.window_ratio);

  assign zero_ratio = warm_q || (l_q == '0);
  assign saturate   = (NUM_W + INT_W)'(num) >= {l_q, {INT_W{1'b0}}};

  // Two restoring division steps per cycle
  always_comb begin
    t1      = {rem, dq[RATIO_W-1]};
    ge1     = t1 >= {1'b0, l_q};
    r1      = ge1 ? SUM_W'(t1 - {1'b0, l_q}) : t1[SUM_W-1:0];
    t2      = {r1, dq[RATIO_W-2]};
    ge2     = t2 >= {1'b0, l_q};
    r2      = ge2 ? SUM_W'(t2 - {1'b0, l_q}) : t2[SUM_W-1:0];
    dq_next = {dq[RATIO_W-3:0], ge1, ge2};
  end

  // Trigger and release with hysteresis
  always_comb begin
    trig    = !active && (ratio_q > cfg.gate_level);
    act_mid = active || trig;
    tc_mid  = trig ? trig_cnt + EVNUM_W'(1) : trig_cnt;
    ti_mid  = trig ? idx_q : trig_idx;
    close   = act_mid && ((ratio_q < cfg.release_level) ||
                          ((idx_q - ti_mid) > cfg.max_event_len));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (q_valid) state_next = B_MUL_LO;
      B_MUL_LO: state_next = B_MUL_HI;
      B_MUL_HI: state_next = B_CHECK;
      B_CHECK:  state_next = (zero_ratio || saturate) ? B_FINISH : B_DIV;
      B_DIV:    if (div_cnt == DIV_CNT_W'(1)) state_next = B_FINISH;
      B_FINISH: if (!result_valid || result_ready) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      B_IDLE:   pop = q_valid;
      B_FINISH: load = !result_valid || result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // Ratio datapath
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (pop) begin
          s_q    <= q_data.short_sum;
          l_q    <= q_data.long_sum;
          idx_q  <= q_data.idx;
          warm_q <= q_data.warm;
        end
      end
      B_MUL_LO: num <= NUM_W'(prod);
      B_MUL_HI: num <= num + (NUM_W'(prod) << MUL_SPLIT);
      B_CHECK: begin
        if (zero_ratio) ratio_q <= '0;
        else if (saturate) ratio_q <= RATIO_MAX;
        rem     <= SUM_W'(num[NUM_W-1:INT_W]);
        dq      <= {num[INT_W-1:0], {FRAC_W{1'b0}}};
        div_cnt <= DIV_CNT_W'(DIV_CYCLES);
      end
      B_DIV: begin
        rem     <= r2;
        dq      <= dq_next;
        div_cnt <= div_cnt - DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(1)) ratio_q <= dq_next;
      end
      B_FINISH: ;
      default: ;
    endcase
  end

  // Event state
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      trig_cnt <= '0;
      trig_idx <= '0;
    end else if (load) begin
      active   <= act_mid && !close;
      trig_cnt <= tc_mid;
      trig_idx <= ti_mid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (load) result_valid <= 1'b1;
    else if (result_ready) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.energy_ratio <= ratio_q;
      result.detecting    <= act_mid && !close;
      result.event_closed <= close;
      result.event_number <= tc_mid;
      result.event_start  <= ti_mid;
      result.event_end    <= close ? idx_q : '0;
    end
  end

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (div_cnt != '0))
    else $error("divider ran past its last step");

  a_close_not_open: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.event_closed) |-> !result.detecting)
    else $error("closed event still reported open");

endmodule
